// ----- rtl/lprr_pkg.sv -----
// Shared types and constants for the length-prefixed record ring.
package lprr_pkg;

    localparam int CFG_W      = 11;    // ring size register width
    localparam int FREE_W     = 11;    // free byte count width
    localparam int MIN_RING   = 11;    // smallest ring size honored
    localparam int CFG_RESET  = 1024;  // ring size after reset

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_DATA  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_DAT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] record_length;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic [7:0]        read_byte;
        logic              end_of_record;
        logic              is_empty;
        logic [FREE_W-1:0] free_bytes;
    } t_out_item;

endpackage

// ----- rtl/lprr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/lprr_ctrl.sv -----
// Pointer state and operation sequencer around the ring memory.
module lprr_ctrl #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  lprr_pkg::t_in_item             i_item,
    input  logic                           i_clear,
    input  logic [$clog2(RING_DEPTH+1)-1:0] i_size,
    output logic                           o_busy,
    output logic                           o_res_valid,
    output lprr_pkg::t_out_item            o_res,
    output logic                           o_ram_we,
    output logic [$clog2(RING_DEPTH)-1:0]  o_ram_waddr,
    output logic [7:0]                     o_ram_wdata,
    output logic [$clog2(RING_DEPTH)-1:0]  o_ram_raddr,
    input  logic [7:0]                     i_ram_rdata
);
    import lprr_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int NW = ((PW > 8) ? PW : 8) + 1;

    t_state         r_state, n_state;
    logic [PW-1:0]  r_head, n_head;
    logic [PW-1:0]  r_tail, n_tail;
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [7:0]     r_wrem, n_wrem;
    logic           r_wact, n_wact;
    logic [7:0]     r_rrem, n_rrem;
    logic           r_ract, n_ract;
    logic [7:0]     r_rlen, n_rlen;
    logic           r_last, n_last;

    logic [NW-1:0]  w_size, w_head, w_tail, w_next, w_wp1;
    logic [7:0]     w_rlen, w_rr_eff;
    logic           w_ok;

    // add modulo ring size with one conditional subtraction; the first operand stays below the size
    function automatic logic [NW-1:0] adv(input logic [NW-1:0] p, input logic [NW-1:0] n,
                                          input logic [NW-1:0] sz);
        logic [NW-1:0] s;
        s = p + n;
        return (s >= sz) ? s - sz : s;
    endfunction

    assign w_size = NW'(i_size);
    assign w_head = NW'(r_head);
    assign w_tail = NW'(r_tail);
    assign w_next = w_head + NW'(i_item.record_length) + NW'(1);
    assign w_ok   = !((w_tail > w_head) && (w_next >= w_tail)) &&
                    !((w_next >= w_size) && ((w_next - w_size) >= w_tail));
    assign w_wp1  = adv(NW'(r_wptr), NW'(1), w_size);
    assign w_rlen = i_ram_rdata;
    assign w_rr_eff = r_ract ? r_rrem : w_rlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_wptr  <= '0;
            r_wrem  <= '0;
            r_wact  <= 1'b0;
            r_rrem  <= '0;
            r_ract  <= 1'b0;
            r_rlen  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_wptr  <= n_wptr;
            r_wrem  <= n_wrem;
            r_wact  <= n_wact;
            r_rrem  <= n_rrem;
            r_ract  <= n_ract;
            r_rlen  <= n_rlen;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_wptr  = r_wptr;
        n_wrem  = r_wrem;
        n_wact  = r_wact;
        n_rrem  = r_rrem;
        n_ract  = r_ract;
        n_rlen  = r_rlen;
        n_last  = r_last;
        o_res_valid = 1'b0;
        o_res.accepted      = 1'b0;
        o_res.read_byte     = '0;
        o_res.end_of_record = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_head;
        o_ram_wdata = i_item.record_length;
        o_ram_raddr = r_tail;

        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    unique case (i_item.op)
                        OP_BEGIN: begin
                            o_res_valid = 1'b1;
                            n_wact = 1'b0;   // any open record is dropped
                            if (w_ok) begin
                                o_ram_we = 1'b1;
                                o_res.accepted = 1'b1;
                                if (i_item.record_length == 8'd0) begin
                                    n_head = PW'(adv(w_head, NW'(1), w_size));
                                end else begin
                                    n_wptr = PW'(adv(w_head, NW'(1), w_size));
                                    n_wrem = i_item.record_length;
                                    n_wact = 1'b1;
                                end
                            end
                        end
                        OP_DATA: begin
                            o_res_valid = 1'b1;
                            if (r_wact) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = r_wptr;
                                o_ram_wdata = i_item.data_byte;
                                o_res.accepted = 1'b1;
                                n_wptr = PW'(w_wp1);
                                n_wrem = r_wrem - 8'd1;
                                if (r_wrem == 8'd1) begin
                                    n_head = PW'(w_wp1);   // commit
                                    n_wact = 1'b0;
                                end
                            end
                        end
                        OP_READ: begin
                            if (r_head != r_tail) begin
                                n_state = ST_LEN;    // fetch length byte at tail
                            end else begin
                                o_res_valid = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            o_res_valid = 1'b1;
                            n_head = '0;
                            n_tail = '0;
                            n_wptr = '0;
                            n_wrem = '0;
                            n_wact = 1'b0;
                            n_rrem = '0;
                            n_ract = 1'b0;
                        end
                    endcase
                end
            end
            ST_LEN: begin
                if ((w_rr_eff == 8'd0) || (w_rr_eff > w_rlen)) begin
                    // empty record: consume it with only the flag
                    o_res_valid = 1'b1;
                    o_res.end_of_record = 1'b1;
                    n_tail  = PW'(adv(w_tail, NW'(w_rlen) + NW'(1), w_size));
                    n_ract  = 1'b0;
                    n_rrem  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_rrem = w_rr_eff - 8'd1;
                    n_ract = (w_rr_eff != 8'd1);
                    n_last = (w_rr_eff == 8'd1);
                    n_rlen = w_rlen;
                    o_ram_raddr = PW'(adv(w_tail,
                                          NW'(1) + NW'(w_rlen) - NW'(w_rr_eff), w_size));
                    n_state = ST_DAT;
                end
            end
            ST_DAT: begin
                o_res_valid = 1'b1;
                o_res.accepted      = 1'b1;
                o_res.read_byte     = i_ram_rdata;
                o_res.end_of_record = r_last;
                if (r_last) begin
                    n_tail = PW'(adv(w_tail, NW'(r_rlen) + NW'(1), w_size));
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a ring size write restarts the ring
        if (i_clear) begin
            n_head = '0;
            n_tail = '0;
            n_wptr = '0;
            n_wrem = '0;
            n_wact = 1'b0;
            n_rrem = '0;
            n_ract = 1'b0;
        end

        o_res.is_empty = (n_head == n_tail);
        if (n_head == n_tail) begin
            o_res.free_bytes = FREE_W'(w_size);
        end else if (n_tail > n_head) begin
            o_res.free_bytes = FREE_W'(NW'(n_tail) - NW'(n_head));
        end else begin
            o_res.free_bytes = FREE_W'(NW'(n_tail) + w_size - NW'(n_head));
        end
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule

// ----- rtl/length_prefixed_record_ring_core.sv -----
// Top level of the length-prefixed record ring: config, sequencer, RAM, result register.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_in_item  (op, record_length, data_byte)
//  output    out        o_out_valid / i_out_ready o_out_item (accepted .. free_bytes)
//  config    in         i_cfg_we                  i_cfg_wdata (ring size)
//
// Begin, data, clear and a read of an empty ring complete from the idle state; a read of a
// nonempty ring ends in the length state (zero-length record) or the data state, as the
// single RAM read port first fetches the length byte at tail, then the payload byte.
// One item is in flight at a time; the next is taken once the result register is
// free or being drained. A stalled output holds its result and blocks new input.
// Synchronous reset clears pointers and sets the ring size to 1024 (clamped to depth);
// the RAM needs no clearing pass.
module length_prefixed_record_ring_core #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  lprr_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lprr_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_we,
    input  logic [lprr_pkg::CFG_W-1:0] i_cfg_wdata
);
    import lprr_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int SW = $clog2(RING_DEPTH + 1);
    localparam int RESET_EFF = (RING_DEPTH < CFG_RESET) ? RING_DEPTH : CFG_RESET;

    logic [SW-1:0] r_size, n_size;
    logic          r_out_valid;
    t_out_item     r_out_item;

    logic          w_accept, w_busy, w_res_valid;
    t_out_item     w_res;
    logic          w_ram_we;
    logic [PW-1:0] w_ram_waddr, w_ram_raddr;
    logic [7:0]    w_ram_wdata, w_ram_rdata;

    always_comb begin
        if (32'(i_cfg_wdata) < MIN_RING) begin
            n_size = SW'(MIN_RING);
        end else if (32'(i_cfg_wdata) > RING_DEPTH) begin
            n_size = SW'(RING_DEPTH);
        end else begin
            n_size = SW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SW'(RESET_EFF);
        end else if (i_cfg_we) begin
            r_size <= n_size;
        end
    end

    assign o_in_ready = !w_busy && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    lprr_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_item),
        .i_clear     (i_cfg_we),
        .i_size      (r_size),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    lprr_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule

// ----- rtl/lprr_checker.sv -----
// Port-level checks for the record ring, bound to the top level.
module lprr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input lprr_pkg::t_in_item         i_in_item,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input lprr_pkg::t_out_item        o_out_item
);
    import lprr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // an empty ring reports at least the minimum ring size as free
    a_empty_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_empty |-> o_out_item.free_bytes >= MIN_RING)
        else $error("empty ring with too few free bytes");

    // read byte is zero unless a byte was returned
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.accepted |-> o_out_item.read_byte == 8'd0)
        else $error("read byte set on a refused transfer");

    // a clear's result shows up in the cycle after it is taken and shows an empty ring
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.op == OP_CLEAR
        |=> o_out_valid && o_out_item.is_empty && !o_out_item.accepted)
        else $error("clear did not empty the ring");
endmodule

bind length_prefixed_record_ring_core lprr_checker u_lprr_checker (.*);

// ----- bench/tb_length_prefixed_record_ring_core.sv -----
// Self-checking testbench for the length-prefixed record ring core.
module tb_length_prefixed_record_ring_core;
    import lprr_pkg::*;

    localparam int MEM_DEPTH   = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 91;
    localparam int CALM_PHASE  = 4;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    // Directed rows start right after reset (ring size 1024).
    localparam t_dir_row SCRIPT [24] = '{
        '{'{OP_READ,  8'd0,   8'd0},   1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, 11'd1024}},
        '{'{OP_DATA,  8'd0,   8'h3C},  1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, 11'd1024}},
        '{'{OP_BEGIN, 8'd0,   8'd0},   1'b1, '{1'b1, 8'd0, 1'b0, 1'b0, 11'd1023}},
        '{'{OP_READ,  8'd0,   8'd0},   1'b1, '{1'b0, 8'd0, 1'b1, 1'b1, 11'd1024}},
        '{'{OP_BEGIN, 8'd255, 8'd0},   1'b1, '{1'b1, 8'd0, 1'b0, 1'b1, 11'd1024}},
        '{'{OP_DATA,  8'd0,   8'hFF},  1'b0, '0},
        '{'{OP_DATA,  8'd0,   8'h00},  1'b0, '0},
        '{'{OP_DATA,  8'd0,   8'h81},  1'b0, '0},
        '{'{OP_BEGIN, 8'd2,   8'd0},   1'b0, '0},
        '{'{OP_DATA,  8'd0,   8'h00},  1'b0, '0},
        '{'{OP_DATA,  8'd0,   8'hFF},  1'b0, '0},
        '{'{OP_READ,  8'd0,   8'd0},   1'b0, '0},
        '{'{OP_READ,  8'd0,   8'd0},   1'b0, '0},
        '{'{OP_READ,  8'd0,   8'd0},   1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, 11'd1024}},
        '{'{OP_BEGIN, 8'd3,   8'd0},   1'b0, '0},
        '{'{OP_DATA,  8'd0,   8'h7E},  1'b0, '0},
        '{'{OP_CLEAR, 8'd0,   8'd0},   1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, 11'd1024}},
        '{'{OP_DATA,  8'd0,   8'h42},  1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, 11'd1024}},
        '{'{OP_BEGIN, 8'd1,   8'd0},   1'b0, '0},
        '{'{OP_DATA,  8'd0,   8'hC3},  1'b0, '0},
        '{'{OP_BEGIN, 8'd0,   8'd0},   1'b0, '0},
        '{'{OP_READ,  8'd0,   8'd0},   1'b0, '0},
        '{'{OP_READ,  8'd0,   8'd0},   1'b0, '0},
        '{'{OP_READ,  8'd0,   8'd0},   1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, 11'd1024}}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out_item;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    length_prefixed_record_ring_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow copy of the ring
    logic [7:0]       ring_mem [MEM_DEPTH];
    logic [CFG_W-1:0] ring_size_reg;
    int               head, tail, wptr, wr_left, rd_left;
    bit               wr_open, rd_open;

    t_out_item        ring_expect [$];
    t_out_item        got_want;
    bit               calm;
    int               errors, cycle_count;
    int               n_sent, n_results, n_admitted, n_refused, n_bytes_read;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_shadow();
        head    = 0;
        tail    = 0;
        wptr    = 0;
        wr_left = 0;
        wr_open = 0;
        rd_left = 0;
        rd_open = 0;
    endfunction

    function automatic t_out_item predict_ring(input t_in_item it);
        int        size, nxt, rlen, off;
        bit        ok;
        t_out_item r;
        r    = '0;
        size = int'(ring_size_reg);
        if (size < MIN_RING) size = MIN_RING;
        if (size > MEM_DEPTH) size = MEM_DEPTH;
        head = head % size;
        tail = tail % size;
        wptr = wptr % size;
        case (it.op)
            OP_BEGIN: begin
                // any open record is dropped; head never moved for it
                nxt     = head + int'(it.record_length) + 1;
                ok      = 1;
                wr_open = 0;
                if (tail > head && nxt >= tail) ok = 0;
                if (ok && nxt >= size && nxt - size >= tail) ok = 0;
                if (ok) begin
                    ring_mem[head] = it.record_length;
                    r.accepted     = 1'b1;
                    if (it.record_length == 0) begin
                        head = (head + 1) % size;
                    end else begin
                        wptr    = (head + 1) % size;
                        wr_left = int'(it.record_length);
                        wr_open = 1;
                    end
                end
            end
            OP_DATA: begin
                if (wr_open) begin
                    ring_mem[wptr] = it.data_byte;
                    wptr           = (wptr + 1) % size;
                    r.accepted     = 1'b1;
                    wr_left--;
                    if (wr_left == 0) begin
                        head    = wptr;
                        wr_open = 0;
                    end
                end
            end
            OP_READ: begin
                if (head != tail) begin
                    rlen = int'(ring_mem[tail]);
                    if (!rd_open) begin
                        rd_left = rlen;
                        rd_open = 1;
                    end
                    if (rd_left == 0 || rd_left > rlen) begin
                        // empty record: consumed, flag only
                        r.end_of_record = 1'b1;
                        tail            = (tail + rlen + 1) % size;
                        rd_open         = 0;
                        rd_left         = 0;
                    end else begin
                        off         = 1 + rlen - rd_left;
                        r.read_byte = ring_mem[(tail + off) % size];
                        r.accepted  = 1'b1;
                        rd_left--;
                        if (rd_left == 0) begin
                            r.end_of_record = 1'b1;
                            tail            = (tail + rlen + 1) % size;
                            rd_open         = 0;
                        end
                    end
                end
            end
            OP_CLEAR: clear_shadow();
            default: ;
        endcase
        r.is_empty   = (head == tail);
        r.free_bytes = (head == tail) ? FREE_W'(size) : FREE_W'((tail + size - head) % size);
        return r;
    endfunction

    // One transfer on the input side; returns the predicted result.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want,
                             output t_out_item pred);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 32 && gap < 20) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_ring(it);
        ring_expect.push_back(typed ? want : pred);
        n_sent++;
        if (it.op == OP_BEGIN) begin
            if (pred.accepted) n_admitted++;
            else n_refused++;
        end
        if (it.op == OP_READ && pred.accepted) n_bytes_read++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (ring_expect.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_ring_size(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        ring_size_reg = v;
        clear_shadow();
    endtask

    // Mostly well-formed records and read bursts, with some truncation and noise.
    task automatic run_phase(input int budget);
        int        done, len, n, k, pick;
        t_in_item  it;
        t_out_item p;
        done = 0;
        while (done < budget) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                len              = ($urandom_range(3) == 0) ? $urandom_range(255)
                                                             : $urandom_range(12);
                it.op            = OP_BEGIN;
                it.record_length = 8'(len);
                it.data_byte     = 8'($urandom);
                send_item(it, 1'b0, '0, p);
                done++;
                if (p.accepted) begin
                    n = ($urandom_range(19) == 0) ? $urandom_range(len) : len;
                    for (k = 0; k < n && done < budget; k++) begin
                        it.op            = OP_DATA;
                        it.record_length = 8'($urandom);
                        it.data_byte     = 8'($urandom);
                        send_item(it, 1'b0, '0, p);
                        done++;
                    end
                end
            end else if (pick < 85) begin
                n = $urandom_range(20, 1);
                for (k = 0; k < n && done < budget; k++) begin
                    it.op            = OP_READ;
                    it.record_length = 8'($urandom);
                    it.data_byte     = 8'($urandom);
                    send_item(it, 1'b0, '0, p);
                    done++;
                    if (!p.accepted && !p.end_of_record) break;
                end
            end else begin
                it.op            = (pick < 89) ? OP_CLEAR : t_op'($urandom_range(3));
                it.record_length = 8'($urandom);
                it.data_byte     = 8'($urandom);
                send_item(it, 1'b0, '0, p);
                done++;
            end
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (ring_expect.size() == 0) begin
                $error("result transfer with no item pending");
                errors++;
            end else begin
                got_want = ring_expect.pop_front();
                check_field("accepted", int'(got_want.accepted),
                            int'(o_out_item.accepted));
                check_field("read_byte", int'(got_want.read_byte),
                            int'(o_out_item.read_byte));
                check_field("end_of_record", int'(got_want.end_of_record),
                            int'(o_out_item.end_of_record));
                check_field("is_empty", int'(got_want.is_empty),
                            int'(o_out_item.is_empty));
                check_field("free_bytes", int'(got_want.free_bytes),
                            int'(o_out_item.free_bytes));
            end
        end
        i_out_ready <= calm || ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL length_prefixed_record_ring_core");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] sizes [N_PHASES];
        t_out_item        p;
        int               i;
        sizes         = '{11'd0, 11'd11, 11'd2047, 11'd12, 11'd300, 11'd1024, 11'd37,
                          11'd0};
        sizes[N_PHASES-1] = CFG_W'($urandom_range(MEM_DEPTH, MIN_RING));
        errors        = 0;
        cycle_count   = 0;
        n_sent        = 0;
        n_results     = 0;
        n_admitted    = 0;
        n_refused     = 0;
        n_bytes_read  = 0;
        calm          = 0;
        ring_size_reg = CFG_W'(CFG_RESET);
        clear_shadow();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(SCRIPT); i++)
            send_item(SCRIPT[i].stim, SCRIPT[i].typed, SCRIPT[i].want, p);

        for (i = 0; i < N_PHASES; i++) begin
            drain();
            calm = (i == CALM_PHASE);
            write_ring_size(sizes[i]);
            run_phase(PHASE_ITEMS);
        end
        drain();
        calm = 0;

        $display("Covered %0d transfers over %0d ring sizes, %0d results checked",
                 n_sent, N_PHASES + 1, n_results);
        $display("Records admitted %0d, begins refused %0d, payload bytes read %0d",
                 n_admitted, n_refused, n_bytes_read);
        if (errors == 0) begin
            $display("PASS length_prefixed_record_ring_core");
        end else begin
            $display("FAIL length_prefixed_record_ring_core");
        end
        $finish;
    end

endmodule
